// File: rtl/color_bar_pattern_gen_assert.svh
// assertion macros used by the pixel pipeline of the color bar pattern generator
`ifndef COLOR_BAR_PATTERN_GEN_ASSERT_SVH
`define COLOR_BAR_PATTERN_GEN_ASSERT_SVH

// checked on clk_i, quiet while rst_ni is low
`define CBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on clk_i, also while in reset
`define CBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/cbp_pkg.sv
// types, constants and color tables of the color bar pattern generator
package cbp_pkg;

  localparam int unsigned SizeW = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SizeW-1:0] MIN_SIZE = 10'd10;
  localparam logic [SizeW-1:0] RESET_WIDTH = 10'd352;
  localparam logic [SizeW-1:0] RESET_HEIGHT = 10'd288;
  localparam logic [SizeW-1:0] EVEN_MASK = 10'h3FE;

  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_CB = 2'd1;
  localparam logic [1:0] PLANE_CR = 2'd2;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  typedef enum logic [3:0] {
    COL_GREY,
    COL_YELLOW,
    COL_CYAN,
    COL_GREEN,
    COL_MAGENTA,
    COL_RED,
    COL_BLUE,
    COL_BLACK,
    COL_I,
    COL_WHITE,
    COL_Q,
    COL_SUPER_BLACK,
    COL_DARK_GREY
  } color_e;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_t;

  typedef struct packed {
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
  } frame_t;

  // bar[i] is the start of top bar i+1, bot[i] of bottom bar i+1,
  // pluge[i] of pluge bar i+1
  typedef struct packed {
    logic [5:0][SizeW-1:0] bar;
    logic [2:0][SizeW-1:0] bot;
    logic [1:0][SizeW-1:0] pluge;
    logic [SizeW-1:0]      row0;
    logic [SizeW-1:0]      row1;
  } edges_t;

  // exact floor(n/7) for n < 7168
  function automatic logic [SizeW-1:0] div7(logic [12:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'(9363);
    return p[25:16];
  endfunction

  // exact floor(n/21) for n < 13107
  function automatic logic [SizeW-1:0] div21(logic [11:0] n);
    logic [25:0] p;
    p = 26'(n) * 26'(3121);
    return p[25:16];
  endfunction

  // exact floor(n/100) for n < 102400
  function automatic logic [SizeW-1:0] div100(logic [16:0] n);
    logic [34:0] p;
    p = 35'(n) * 35'(167773);
    return p[33:24];
  endfunction

  function automatic color_e top_color(logic [2:0] k);
    color_e c;
    case (k)
      3'd0:    c = COL_GREY;
      3'd1:    c = COL_YELLOW;
      3'd2:    c = COL_CYAN;
      3'd3:    c = COL_GREEN;
      3'd4:    c = COL_MAGENTA;
      3'd5:    c = COL_RED;
      default: c = COL_BLUE;
    endcase
    return c;
  endfunction

  function automatic color_e mid_color(logic [2:0] k);
    color_e c;
    case (k)
      3'd0:    c = COL_BLUE;
      3'd2:    c = COL_MAGENTA;
      3'd4:    c = COL_CYAN;
      3'd6:    c = COL_GREY;
      3'd7:    c = COL_GREY;
      default: c = COL_BLACK;
    endcase
    return c;
  endfunction

  function automatic color_e low_color(logic [1:0] k);
    color_e c;
    case (k)
      2'd0:    c = COL_I;
      2'd1:    c = COL_WHITE;
      2'd2:    c = COL_Q;
      default: c = COL_BLACK;
    endcase
    return c;
  endfunction

  function automatic color_e pluge_color(logic [1:0] k);
    color_e c;
    case (k)
      2'd0:    c = COL_SUPER_BLACK;
      2'd1:    c = COL_BLACK;
      default: c = COL_DARK_GREY;
    endcase
    return c;
  endfunction

  // bt.601 values of the bar colors, truncated
  function automatic ycc_t color_ycc(color_e c);
    ycc_t v;
    case (c)
      COL_GREY:        v = '{8'd191, 8'd128, 8'd128};
      COL_YELLOW:      v = '{8'd210, 8'd16,  8'd146};
      COL_CYAN:        v = '{8'd169, 8'd165, 8'd16};
      COL_GREEN:       v = '{8'd144, 8'd53,  8'd34};
      COL_MAGENTA:     v = '{8'd106, 8'd202, 8'd221};
      COL_RED:         v = '{8'd81,  8'd90,  8'd239};
      COL_BLUE:        v = '{8'd40,  8'd239, 8'd109};
      COL_BLACK:       v = '{8'd32,  8'd128, 8'd128};
      COL_I:           v = '{8'd58,  8'd147, 8'd102};
      COL_WHITE:       v = '{8'd235, 8'd128, 8'd128};
      COL_Q:           v = '{8'd43,  8'd174, 8'd144};
      COL_SUPER_BLACK: v = '{8'd16,  8'd128, 8'd128};
      COL_DARK_GREY:   v = '{8'd48,  8'd128, 8'd128};
      default:         v = '{8'd32,  8'd128, 8'd128};
    endcase
    return v;
  endfunction

endpackage

// File: rtl/color_bar_pattern_gen.sv
// top level of the planar ycbcr 4:2:0 color bar pattern generator
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   plane_i, column_i, line_i
// out       output     out_valid_o / out_stall_i pixel_value_o
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one transfer per cycle while in_stall_o is low; each result passes through the
// input, bounds, bar select and color lookup registers of the pipeline
// edges follow size writes and reset via their register stages, ahead of items using them
// reset gives a 352 x 288 frame and an empty pipeline
// out_stall_i holds the output register; in_stall_o rises only when all four stages are full
module color_bar_pattern_gen #(
  parameter int unsigned MAX_WIDTH  = 1000,
  parameter int unsigned MAX_HEIGHT = 800
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cbp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cbp_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  plane_i,
  input  logic [cbp_pkg::SizeW-1:0]   column_i,
  input  logic [cbp_pkg::SizeW-1:0]   line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  pixel_value_o
);
  import cbp_pkg::*;

  frame_t frame_d, frame_q;
  edges_t edges;
  logic [SizeW-1:0] w_clamped, h_clamped;

  // odd sizes are kept as written
  always_comb begin
    if (cfg_wdata_i < MIN_SIZE) begin
      w_clamped = MIN_SIZE;
    end else if (32'(cfg_wdata_i) > MAX_WIDTH) begin
      w_clamped = SizeW'(MAX_WIDTH);
    end else begin
      w_clamped = cfg_wdata_i;
    end
    if (cfg_wdata_i < MIN_SIZE) begin
      h_clamped = MIN_SIZE;
    end else if (32'(cfg_wdata_i) > MAX_HEIGHT) begin
      h_clamped = SizeW'(MAX_HEIGHT);
    end else begin
      h_clamped = cfg_wdata_i;
    end

    frame_d = frame_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_d.w = w_clamped;
        REG_FRAME_HEIGHT: frame_d.h = h_clamped;
        default:          frame_d = frame_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q.w <= RESET_WIDTH;
      frame_q.h <= RESET_HEIGHT;
    end else begin
      frame_q <= frame_d;
    end
  end

  // edges are fed from the next size so they lead the pixel pipeline
  cbp_edges u_edges (
    .clk_i   (clk_i),
    .frame_i (frame_d),
    .edges_o (edges)
  );

  cbp_pixel_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .plane_i       (plane_i),
    .column_i      (column_i),
    .line_i        (line_i),
    .frame_i       (frame_q),
    .edges_i       (edges),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_value_o (pixel_value_o)
  );

endmodule

// File: rtl/cbp_edges.sv
// bar, bottom and row edge computation from the frame size
module cbp_edges (
  input  logic            clk_i,
  input  cbp_pkg::frame_t frame_i,
  output cbp_pkg::edges_t edges_o
);
  import cbp_pkg::*;

  // first stage: products with reciprocals
  logic [5:0][SizeW-1:0] bar_d, bar_q;
  logic [SizeW-1:0]      rowraw_d, rowraw_q;
  logic [SizeW-1:0]      h34_d, h34_q;
  logic [SizeW-1:0]      w21a_d, w21a_q;
  logic [SizeW-1:0]      w21b_d, w21b_q;

  // second stage: edges derived from first-stage edges
  logic [2:0][SizeW-1:0] bot_d, bot_q;
  logic [1:0][SizeW-1:0] pluge_d, pluge_q;
  logic [SizeW-1:0]      row0_d, row0_q;
  logic [SizeW-1:0]      row1_d, row1_q;
  logic [11:0]           h3;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      bar_d[i] = div7(13'(i + 1) * 13'(frame_i.w)) & EVEN_MASK;
    end
    rowraw_d = div100(17'(frame_i.h) * 17'(66));
    h3       = 12'(frame_i.h) * 12'(3);
    h34_d    = h3[11:2];
    w21a_d   = div21(12'(frame_i.w));
    w21b_d   = div21(12'({frame_i.w, 1'b0}));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bot_d[i] = 10'((12'(i + 1) * 12'(bar_q[4])) >> 2) & EVEN_MASK;
    end
    pluge_d[0] = 10'(11'(bar_q[3]) + 11'(w21a_q)) & EVEN_MASK;
    pluge_d[1] = 10'(11'(bar_q[3]) + 11'(w21b_q)) & EVEN_MASK;
    row0_d     = rowraw_q & EVEN_MASK;
    row1_d     = row0_d + ((h34_q - rowraw_q) & EVEN_MASK);
  end

  // derived data, recomputed every cycle from the incoming frame size
  always_ff @(posedge clk_i) begin
    bar_q    <= bar_d;
    rowraw_q <= rowraw_d;
    h34_q    <= h34_d;
    w21a_q   <= w21a_d;
    w21b_q   <= w21b_d;
    bot_q    <= bot_d;
    pluge_q  <= pluge_d;
    row0_q   <= row0_d;
    row1_q   <= row1_d;
  end

  assign edges_o.bar   = bar_q;
  assign edges_o.bot   = bot_q;
  assign edges_o.pluge = pluge_q;
  assign edges_o.row0  = row0_q;
  assign edges_o.row1  = row1_q;

endmodule

// File: rtl/cbp_pixel_pipe.sv
// four-stage pixel pipeline: input, bounds, bar select, color lookup
module cbp_pixel_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               plane_i,
  input  logic [cbp_pkg::SizeW-1:0] column_i,
  input  logic [cbp_pkg::SizeW-1:0] line_i,
  input  cbp_pkg::frame_t          frame_i,
  input  cbp_pkg::edges_t          edges_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [7:0]               pixel_value_o
);
  import cbp_pkg::*;

  `include "color_bar_pattern_gen_assert.svh"

  logic v1_q, v2_q, v3_q, out_v_q;
  logic adv1, adv2, adv3, adv_out;

  logic [1:0]       s1_plane_q;
  logic [SizeW-1:0] s1_col_q, s1_line_q;

  logic [1:0]       s2_plane_d, s2_plane_q;
  logic [SizeW:0]   s2_x_d, s2_x_q, s2_y_d, s2_y_q;
  logic             s2_blank_d, s2_blank_q;

  logic [1:0]       s3_plane_q;
  logic             s3_blank_q;
  color_e           s3_color_d, s3_color_q;
  logic [2:0]       k_bar;
  logic [1:0]       k_low, k_plg;

  ycc_t             ycc;
  logic [7:0]       pixel_d, pixel_q;

  // a stage loads when it is empty or its content moves on
  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv3       = !v3_q || adv_out;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;

  // chroma positions map to the luma pixel at twice the coordinates
  always_comb begin
    s2_plane_d = s1_plane_q;
    if (s1_plane_q == PLANE_Y) begin
      s2_x_d = {1'b0, s1_col_q};
      s2_y_d = {1'b0, s1_line_q};
    end else begin
      s2_x_d = {s1_col_q, 1'b0};
      s2_y_d = {s1_line_q, 1'b0};
    end
    s2_blank_d = (s1_plane_q == PLANE_NONE) || (s2_x_d >= {1'b0, frame_i.w}) ||
                 (s2_y_d >= {1'b0, frame_i.h});
  end

  always_comb begin
    k_bar = '0;
    for (int i = 0; i < 6; i++) begin
      k_bar = k_bar + 3'(s2_x_q >= {1'b0, edges_i.bar[i]});
    end
    k_low = '0;
    for (int i = 0; i < 3; i++) begin
      k_low = k_low + 2'(s2_x_q >= {1'b0, edges_i.bot[i]});
    end
    k_plg = 2'(s2_x_q >= {1'b0, edges_i.pluge[0]}) + 2'(s2_x_q >= {1'b0, edges_i.pluge[1]});

    if (s2_y_q < {1'b0, edges_i.row0}) begin
      s3_color_d = top_color(k_bar);
    end else if (s2_y_q < {1'b0, edges_i.row1}) begin
      s3_color_d = mid_color(k_bar);
    end else if (s2_x_q >= {1'b0, edges_i.bar[4]}) begin
      s3_color_d = COL_BLACK;
    end else if (s2_x_q >= {1'b0, edges_i.bar[3]}) begin
      s3_color_d = pluge_color(k_plg);
    end else begin
      s3_color_d = low_color(k_low);
    end
  end

  always_comb begin
    ycc = color_ycc(s3_color_q);
    case (s3_plane_q)
      PLANE_Y:  pixel_d = ycc.y;
      PLANE_CB: pixel_d = ycc.cb;
      PLANE_CR: pixel_d = ycc.cr;
      default:  pixel_d = '0;
    endcase
    if (s3_blank_q) begin
      pixel_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
      if (adv_out) begin
        out_v_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_plane_q <= plane_i;
      s1_col_q   <= column_i;
      s1_line_q  <= line_i;
    end
    if (adv2) begin
      s2_plane_q <= s2_plane_d;
      s2_x_q     <= s2_x_d;
      s2_y_q     <= s2_y_d;
      s2_blank_q <= s2_blank_d;
    end
    if (adv3) begin
      s3_plane_q <= s2_plane_q;
      s3_blank_q <= s2_blank_q;
      s3_color_q <= s3_color_d;
    end
    if (adv_out) begin
      pixel_q <= pixel_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign pixel_value_o = pixel_q;

  // occupancy bookkeeping for the checks
  logic [2:0] occ;
  logic       acc, dlv;
  assign occ = 3'(v1_q) + 3'(v2_q) + 3'(v3_q) + 3'(out_v_q);
  assign acc = in_valid_i && !in_stall_o;
  assign dlv = out_v_q && !out_stall_i;

  `CBP_ASSERT(a_stall_only_when_full, in_stall_o |-> (v1_q && v2_q && v3_q && out_v_q), "input stalled with a free stage")
  `CBP_ASSERT(a_items_conserved, $past(rst_ni) |-> (occ == 3'($past(occ) + 3'($past(acc)) - 3'($past(dlv)))), "transfer lost or duplicated in pipeline")
  `CBP_ASSERT_RST(a_reset_empty, !rst_ni |=> (!out_valid_o && !in_stall_o), "pipeline not empty in reset")

endmodule
